// File: rtl/cve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cve_pkg
// Shared types, character codes and base helpers for the variant extractor.
// ----------------------------------------------------------------------------
package cve_pkg;

   localparam int unsigned MAX_RUN = 64;
   localparam int RUN_W = $clog2(MAX_RUN + 1);

   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_CIGAR = 2'd1;
   localparam logic [1:0] KIND_PAIR  = 2'd2;

   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_9  = 8'h39;
   localparam logic [7:0] CH_EQ = 8'h3D;
   localparam logic [7:0] CH_A  = 8'h41;
   localparam logic [7:0] CH_C  = 8'h43;
   localparam logic [7:0] CH_D  = 8'h44;
   localparam logic [7:0] CH_G  = 8'h47;
   localparam logic [7:0] CH_I  = 8'h49;
   localparam logic [7:0] CH_M  = 8'h4D;
   localparam logic [7:0] CH_N  = 8'h4E;
   localparam logic [7:0] CH_T  = 8'h54;
   localparam logic [7:0] CH_U  = 8'h55;
   localparam logic [7:0] CH_LA = 8'h61;
   localparam logic [7:0] CH_LZ = 8'h7A;

   localparam logic [4:0] CODE_MATCH      = 5'd0;
   localparam logic [4:0] CODE_SUBST_BASE = 5'd4;
   localparam logic [4:0] CODE_DEL        = 5'd16;
   localparam logic [4:0] CODE_INS        = 5'd17;
   localparam logic [4:0] CODE_INTRON     = 5'd18;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] start_pos;
      logic        minus_strand;
      logic [7:0]  cigar_byte;
      logic [7:0]  ref_base;
      logic [7:0]  read_base;
   } cve_req_type;

   typedef struct packed {
      logic [31:0] position;
      logic [4:0]  code;
      logic        last;
      logic        error;
   } cve_rsp_type;

   // Follow-up work an accepted item needs after its transfer
   typedef enum logic [2:0] {
      WORK_NONE,
      WORK_PAIR,
      WORK_DEL,
      WORK_DEL_LONG,
      WORK_INS,
      WORK_INTRON
   } cve_work_type;

   // One result-producing step of the datapath
   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_PAIR,
      STEP_DEL,
      STEP_DEL_LONG,
      STEP_INS,
      STEP_N_HEAD,
      STEP_N_TAIL
   } cve_step_type;

   typedef struct packed {
      logic         take;
      cve_step_type step;
   } cve_cmd_type;

   typedef struct packed {
      cve_work_type work;
      logic         run_one;
      logic         out_free;
   } cve_sts_type;

   function automatic logic [7:0] norm_base(input logic [7:0] ch, input logic minus);
      logic [7:0] up;
      logic [7:0] res;
      up = (ch inside {[CH_LA:CH_LZ]}) ? ch - 8'd32 : ch;
      res = up;
      if (minus) begin
         case (up)
            CH_A:       res = CH_T;
            CH_C:       res = CH_G;
            CH_G:       res = CH_C;
            CH_T, CH_U: res = CH_A;
            default:    res = up;
         endcase
      end
      return res;
   endfunction

   // bit 2 set means not one of A, C, G, T
   function automatic logic [2:0] base_idx(input logic [7:0] ch);
      logic [2:0] idx;
      case (ch)
         CH_A:    idx = 3'd0;
         CH_C:    idx = 3'd1;
         CH_G:    idx = 3'd2;
         CH_T:    idx = 3'd3;
         default: idx = 3'd4;
      endcase
      return idx;
   endfunction

   function automatic logic [4:0] subst_code(input logic [7:0] a, input logic [7:0] b);
      logic [2:0] ia;
      logic [2:0] ib;
      logic [4:0] code;
      ia = base_idx(a);
      ib = base_idx(b);
      if (ia[2] || ib[2] || ia == ib) begin
         code = CODE_MATCH;
      end else begin
         code = CODE_SUBST_BASE + 5'(ia[1:0]) * 5'd3
              + ((ib > ia) ? 5'(ib[1:0]) - 5'd1 : 5'(ib[1:0]));
      end
      return code;
   endfunction

endpackage

// File: rtl/cve_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cve_datapath
// Alignment state, CIGAR decode, position adder and the result register.
// ----------------------------------------------------------------------------
module cve_datapath
   import cve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cve_req_type req_payload,
   input  cve_cmd_type cmd,
   output cve_sts_type sts,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output cve_rsp_type rsp_payload
);

   logic [31:0]      pos_ff, pos_in;
   logic [31:0]      len_ff, len_in;
   logic [31:0]      cols_ff, cols_in;
   logic             strand_ff, strand_in;
   logic [31:0]      oplen_ff, oplen_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             pair_hit_ff, pair_hit_in;
   logic [4:0]       pair_code_ff, pair_code_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cve_rsp_type      rsp_ff, rsp_in;

   logic             is_digit;
   logic             is_match;
   logic [35:0]      len_x10;
   logic [31:0]      len_sat;
   logic [7:0]       ref_norm;
   logic [7:0]       read_norm;
   logic [31:0]      pos_addend;
   logic             emit;
   cve_rsp_type      emit_data;
   cve_work_type     work;

   assign is_digit  = req_payload.cigar_byte inside {[CH_0:CH_9]};
   assign is_match  = (req_payload.cigar_byte == CH_M) || (req_payload.cigar_byte == CH_EQ);
   assign len_x10   = {1'b0, len_ff, 3'b000} + {3'b000, len_ff, 1'b0}
                    + 36'(req_payload.cigar_byte - CH_0);
   assign len_sat   = (len_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : len_x10[31:0];
   assign ref_norm  = norm_base(req_payload.ref_base, strand_ff);
   assign read_norm = norm_base(req_payload.read_base, strand_ff);

   always_comb begin
      work = WORK_NONE;
      case (req_payload.kind)
         KIND_PAIR: work = WORK_PAIR;
         KIND_CIGAR: begin
            if (!is_digit) begin
               case (req_payload.cigar_byte)
                  CH_D: begin
                     if (len_ff == 32'd0) begin
                        work = WORK_NONE;
                     end else if (len_ff > 32'(MAX_RUN)) begin
                        work = WORK_DEL_LONG;
                     end else begin
                        work = WORK_DEL;
                     end
                  end
                  CH_I:    work = WORK_INS;
                  CH_N:    work = WORK_INTRON;
                  default: work = WORK_NONE;
               endcase
            end
         end
         default: work = WORK_NONE;
      endcase
   end

   assign sts.work     = work;
   assign sts.run_one  = (run_ff == RUN_W'(1));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // one shared adder moves the reference position
   always_comb begin
      pos_addend = 32'd0;
      if (cmd.take) begin
         pos_addend = cols_ff;
      end else begin
         case (cmd.step)
            STEP_PAIR:     pos_addend = (cols_ff != 32'd0) ? 32'd1 : 32'd0;
            STEP_DEL:      pos_addend = 32'd1;
            STEP_DEL_LONG: pos_addend = oplen_ff;
            STEP_N_HEAD:   pos_addend = oplen_ff;
            default:       pos_addend = 32'd0;
         endcase
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      len_in       = len_ff;
      cols_in      = cols_ff;
      strand_in    = strand_ff;
      oplen_in     = oplen_ff;
      run_in       = run_ff;
      pair_hit_in  = pair_hit_ff;
      pair_code_in = pair_code_ff;
      emit         = 1'b0;
      emit_data    = '{position: pos_ff, code: CODE_MATCH, last: 1'b1, error: 1'b0};

      if (cmd.take) begin
         case (req_payload.kind)
            KIND_BEGIN: begin
               pos_in    = req_payload.start_pos;
               strand_in = req_payload.minus_strand;
               len_in    = 32'd0;
               cols_in   = 32'd0;
            end
            KIND_CIGAR: begin
               if (is_digit) begin
                  len_in = len_sat;
               end else begin
                  // skip columns still armed, then act on the operation
                  pos_in   = pos_ff + pos_addend;
                  cols_in  = is_match ? len_ff : 32'd0;
                  len_in   = 32'd0;
                  oplen_in = len_ff;
                  run_in   = len_ff[RUN_W-1:0];
               end
            end
            KIND_PAIR: begin
               pair_hit_in  = (ref_norm != read_norm) && (ref_norm != CH_N)
                            && (read_norm != CH_N);
               pair_code_in = subst_code(ref_norm, read_norm);
            end
            default: ;
         endcase
      end else begin
         case (cmd.step)
            STEP_PAIR: begin
               if (cols_ff == 32'd0) begin
                  emit            = 1'b1;
                  emit_data.error = 1'b1;
               end else begin
                  emit           = pair_hit_ff;
                  emit_data.code = pair_code_ff;
                  pos_in         = pos_ff + pos_addend;
                  cols_in        = cols_ff - 32'd1;
               end
            end
            STEP_DEL: begin
               emit           = 1'b1;
               emit_data.code = CODE_DEL;
               emit_data.last = (run_ff == RUN_W'(1));
               pos_in         = pos_ff + pos_addend;
               run_in         = run_ff - RUN_W'(1);
            end
            STEP_DEL_LONG: begin
               emit            = 1'b1;
               emit_data.code  = CODE_DEL;
               emit_data.error = 1'b1;
               pos_in          = pos_ff + pos_addend;
            end
            STEP_INS: begin
               emit           = 1'b1;
               emit_data.code = CODE_INS;
            end
            STEP_N_HEAD: begin
               emit           = 1'b1;
               emit_data.code = CODE_INTRON;
               emit_data.last = 1'b0;
               pos_in         = pos_ff + pos_addend;
            end
            STEP_N_TAIL: begin
               emit           = 1'b1;
               emit_data.code = CODE_INTRON;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = emit ? emit_data : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 32'd0;
         len_ff       <= 32'd0;
         cols_ff      <= 32'd0;
         strand_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         cols_ff      <= cols_in;
         strand_ff    <= strand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      oplen_ff     <= oplen_in;
      run_ff       <= run_in;
      pair_hit_ff  <= pair_hit_in;
      pair_code_ff <= pair_code_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_step_lands : assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted result did not reach the result register");

   a_error_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.error) |-> rsp_ff.last)
      else $error("error result not marked last");

   a_del_advances : assert property (@(posedge clock) disable iff (reset)
      (!cmd.take && cmd.step == STEP_DEL) |=> pos_ff == $past(pos_ff) + 32'd1)
      else $error("deletion column did not advance position");

endmodule

// File: rtl/cve_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cve_ctrl
// Sequencer: takes one item, then steps out its results one per free slot.
// ----------------------------------------------------------------------------
module cve_ctrl
   import cve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  cve_sts_type sts,
   output cve_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAIR,
      ST_DEL,
      ST_DEL_LONG,
      ST_INS,
      ST_N_HEAD,
      ST_N_TAIL
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd.take = 1'b0;
      cmd.step = STEP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               cmd.take = 1'b1;
               case (sts.work)
                  WORK_PAIR:     state_in = ST_PAIR;
                  WORK_DEL:      state_in = ST_DEL;
                  WORK_DEL_LONG: state_in = ST_DEL_LONG;
                  WORK_INS:      state_in = ST_INS;
                  WORK_INTRON:   state_in = ST_N_HEAD;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_PAIR: begin
            if (sts.out_free) begin
               cmd.step = STEP_PAIR;
               state_in = ST_IDLE;
            end
         end
         ST_DEL: begin
            if (sts.out_free) begin
               cmd.step = STEP_DEL;
               if (sts.run_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DEL_LONG: begin
            if (sts.out_free) begin
               cmd.step = STEP_DEL_LONG;
               state_in = ST_IDLE;
            end
         end
         ST_INS: begin
            if (sts.out_free) begin
               cmd.step = STEP_INS;
               state_in = ST_IDLE;
            end
         end
         ST_N_HEAD: begin
            if (sts.out_free) begin
               cmd.step = STEP_N_HEAD;
               state_in = ST_N_TAIL;
            end
         end
         ST_N_TAIL: begin
            if (sts.out_free) begin
               cmd.step = STEP_N_TAIL;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

   a_step_has_slot : assert property (@(posedge clock) disable iff (reset)
      (cmd.step != STEP_NONE) |-> sts.out_free)
      else $error("result step issued while result register is blocked");

   a_no_take_while_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.take)
      else $error("item taken while a previous item is still in work");

endmodule

// File: rtl/cigar_variant_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_variant_extractor
// Walks one alignment's CIGAR bytes and base pairs and reports variations.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    cve_req_type (begin, CIGAR byte, base pair)
//  rsp      out        rsp_valid/stall    cve_rsp_type (position, code, last, error)
//
//  Begin items, digits and letters without results (M, =, S, H, P, X, ...) need no result step;
//  base pairs and I get a result step, N a head and a tail step, and D of length L a step per
//  base (an error step when overlong); the controller issues one result per cycle into a single
//  result register. Each result step waits while rsp_stall holds a result in that register.
//  Reset is synchronous; req_stall is high during reset and the cycle after it.
// ----------------------------------------------------------------------------
module cigar_variant_extractor
   import cve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  cve_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output cve_rsp_type rsp_payload
);

   cve_cmd_type cmd;
   cve_sts_type sts;

   cve_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cve_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
